// ===== design/swd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swd_pkg: shared types and constants of the sticky worker dispatcher
// Word formats of the request and response channels, operation codes,
// default sizing and the small arithmetic helpers used by the core.
// ----------------------------------------------------------------------------
package swd_pkg;

   // default sizing, handed to the top level parameters
   localparam int DefWorkers   = 4;
   localparam int DefClients   = 16;
   localparam int DefQueueSize = 64;
   localparam int DefRateLimit = 3;

   // operation codes
   localparam logic [1:0] OpSetSpeed = 2'd0;
   localparam logic [1:0] OpDispatch = 2'd1;
   localparam logic [1:0] OpComplete = 2'd2;

   // counters saturate here
   localparam logic [7:0] CountMax = 8'd255;

   // scale of the rate factor in the drop threshold
   localparam logic [15:0] RateScale = 16'd1000;

   typedef struct packed {
      logic [1:0] operation;
      logic [3:0] client_idx;
      logic [5:0] speed_value;
      logic [9:0] random_value;
      logic [1:0] worker_idx;
   } req_type;

   typedef struct packed {
      logic [1:0] assigned_worker;
      logic       dropped;
      logic [7:0] worker_load;
      logic       underflow;
   } rsp_type;

   // x / 3 for x up to 127, by reciprocal multiply
   function automatic logic [5:0] div3(input logic [6:0] x);
      logic [15:0] prod;
      prod = 16'(x) * 16'd171;
      return 6'(prod >> 9);
   endfunction

endpackage
`default_nettype wire

// ===== design/swd_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swd_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module swd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                        clock,
   input  wire logic                                        wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                            wr_data,
   input  wire logic                                        rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                            rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // storage array
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== design/sticky_worker_dispatcher_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sticky_worker_dispatcher_core: client-affine request dispatcher
// Keeps per-client speed, binding and pending count in a client table RAM and
// per-worker load in registers; sets speed, dispatches, drops or completes one
// word at a time.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; each word gives exactly
// one response, shown on rsp_data for a single cycle with rsp_strobe high, and
// the receiver has no way to hold it off. The accepting edge reads the client
// table, the calc state picks the worker and forms the load square and rate
// products, and the commit state does the final multiply, the drop compare and
// the write-back. The response strobe is up in the cycle after the commit state,
// and start is taken again in that same cycle, so a new word is taken only once
// the last is through; the pace is set by the client table read latency and the
// two-step multiply chain. The table needs no clearing pass after reset:
// per-entry written bits make an unwritten client read as its reset value.
// ----------------------------------------------------------------------------
module sticky_worker_dispatcher_core
   import swd_pkg::*;
#(
   parameter int WORKERS    = DefWorkers,
   parameter int CLIENTS    = DefClients,
   parameter int QUEUE_SIZE = DefQueueSize,
   parameter int RATE_LIMIT = DefRateLimit
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_strobe,
   output rsp_type      rsp_data
);
   // sizing
   localparam int WorkerBits  = (WORKERS > 1) ? $clog2(WORKERS) : 1;
   localparam int ClientDepth = (CLIENTS < 16) ? CLIENTS : 16;
   localparam int ClientBits  = (ClientDepth > 1) ? $clog2(ClientDepth) : 1;
   localparam int ClientSlots = 1 << ClientBits;
   localparam int EntryWidth  = 6 + 1 + WorkerBits + 8;

   localparam int LoadFactorRaw = (QUEUE_SIZE * QUEUE_SIZE) / (WORKERS * WORKERS);
   localparam int LoadFactor    = (LoadFactorRaw == 0) ? 1 : LoadFactorRaw;

   localparam logic [8:0]            ClientLimit = 9'(CLIENTS);
   localparam logic [4:0]            WorkerLimit = 5'(WORKERS);
   localparam logic [5:0]            SpeedBias   = 6'(RATE_LIMIT - 1);
   localparam logic [WorkerBits-1:0] TurnLast    = WorkerBits'(WORKERS - 1);
   localparam logic [EntryWidth-1:0] EntryReset  =
      {6'd1, 1'b0, {WorkerBits{1'b0}}, 8'd0};

   // sequencer states
   localparam logic [1:0] StIdle   = 2'd0;
   localparam logic [1:0] StCalc   = 2'd1;
   localparam logic [1:0] StCommit = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       accept;

   // captured word and table address
   req_type               req_ff;
   logic [ClientBits-1:0] addr_ff;

   // client table
   logic                  tbl_wr_en;
   logic [EntryWidth-1:0] tbl_wr_data;
   logic [EntryWidth-1:0] tbl_rd_data;
   logic [ClientSlots-1:0] written_ff;

   // worker loads and turn
   logic [7:0]            load_ff [WORKERS];
   logic                  load_we;
   logic [7:0]            load_in;
   logic [WorkerBits-1:0] turn_ff, turn_in;

   // calc stage
   logic [EntryWidth-1:0] entry_rd;
   logic [5:0]            ent_speed;
   logic                  ent_valid;
   logic [WorkerBits-1:0] ent_worker;
   logic                  wid_ok;
   logic [WorkerBits-1:0] bound_w, sel_w;
   logic [5:0]            rf;
   logic [7:0]            len_sel;

   logic [EntryWidth-1:0] entry_ff;
   logic [WorkerBits-1:0] sel_w_ff;
   logic [7:0]            len_ff;
   logic [15:0]           lensq_ff, lensq_in;
   logic [15:0]           rf1000_ff, rf1000_in;
   logic [26:0]           rndf_ff, rndf_in;
   logic                  wid_ok_ff;

   // commit stage
   logic [31:0]           pressure;
   logic                  drop;
   logic                  cid_ok;
   logic [7:0]            pend;
   logic [7:0]            pend_dec;
   logic [7:0]            len_inc, len_dec;
   logic [7:0]            pend_inc;

   logic    rsp_strobe_ff;
   rsp_type rsp_data_ff, rsp_in;

   assign accept = start && (state_ff == StIdle);
   assign busy   = (state_ff != StIdle);

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         StIdle:   if (accept) state_in = StCalc;
         StCalc:   state_in = StCommit;
         StCommit: state_in = StIdle;
         default:  state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
      end else begin
         state_ff <= state_in;
      end
   end

   // capture the word on accept
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff  <= req_data;
         addr_ff <= req_data.client_idx[ClientBits-1:0];
      end
   end

   swd_ram #(
      .WIDTH (EntryWidth),
      .DEPTH (ClientSlots)
   ) u_client_tbl (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (addr_ff),
      .wr_data (tbl_wr_data),
      .rd_en   (accept),
      .rd_addr (req_data.client_idx[ClientBits-1:0]),
      .rd_data (tbl_rd_data)
   );

   // calc: resolve entry, pick worker, form products
   always_comb begin
      entry_rd   = written_ff[addr_ff] ? tbl_rd_data : EntryReset;
      ent_speed  = entry_rd[EntryWidth-1 -: 6];
      ent_valid  = entry_rd[WorkerBits+8];
      ent_worker = entry_rd[WorkerBits+7:8];
      bound_w    = ent_valid ? ent_worker : turn_ff;
      wid_ok     = ({3'd0, req_ff.worker_idx} < WorkerLimit);
      if (req_ff.operation == OpComplete) begin
         sel_w = wid_ok ? WorkerBits'(req_ff.worker_idx) : '0;
      end else begin
         sel_w = bound_w;
      end
      len_sel  = load_ff[sel_w];
      lensq_in = 16'(len_sel) * 16'(len_sel);
      // rate factor, only its positive part can cause a drop
      if (ent_speed > SpeedBias) begin
         rf = div3({ent_speed - SpeedBias, 1'b0});
      end else begin
         rf = 6'd0;
      end
      rf1000_in = 16'(rf) * RateScale;
      rndf_in   = (27'(req_ff.random_value) + 27'd1) * 27'(LoadFactor);
   end

   always_ff @(posedge clock) begin
      if (state_ff == StCalc) begin
         entry_ff  <= entry_rd;
         sel_w_ff  <= sel_w;
         len_ff    <= len_sel;
         lensq_ff  <= lensq_in;
         rf1000_ff <= rf1000_in;
         rndf_ff   <= rndf_in;
         wid_ok_ff <= wid_ok;
      end
   end

   // commit: drop when (rnd+1)*factor <= rf*1000*len^2, i.e. rnd < threshold
   always_comb begin
      pressure = 32'(rf1000_ff) * 32'(lensq_ff);
      drop     = ({5'd0, rndf_ff} <= pressure);
      cid_ok   = ({5'd0, req_ff.client_idx} < ClientLimit);
      pend     = entry_ff[7:0];
      pend_inc = (pend == CountMax) ? pend : pend + 8'd1;
      pend_dec = pend - 8'd1;
      len_inc  = (len_ff == CountMax) ? len_ff : len_ff + 8'd1;
      len_dec  = len_ff - 8'd1;

      tbl_wr_en   = 1'b0;
      tbl_wr_data = entry_ff;
      load_we     = 1'b0;
      load_in     = len_ff;
      turn_in     = turn_ff;
      rsp_in      = '0;

      if ((state_ff == StCommit) && cid_ok) begin
         unique case (req_ff.operation)
            OpSetSpeed: begin
               tbl_wr_en   = 1'b1;
               tbl_wr_data = {req_ff.speed_value, entry_ff[EntryWidth-7:0]};
            end
            OpDispatch: begin
               // binding is kept even when the word is dropped
               tbl_wr_en = 1'b1;
               if (drop) begin
                  tbl_wr_data = {entry_ff[EntryWidth-1 -: 6], 1'b1, sel_w_ff, pend};
                  rsp_in.worker_load = len_ff;
               end else begin
                  tbl_wr_data = {entry_ff[EntryWidth-1 -: 6], 1'b1, sel_w_ff, pend_inc};
                  load_we     = 1'b1;
                  load_in     = len_inc;
                  rsp_in.worker_load = len_inc;
                  if (sel_w_ff == turn_ff) begin
                     turn_in = (turn_ff == TurnLast) ? '0 : turn_ff + 1'b1;
                  end
               end
               rsp_in.assigned_worker = 2'(sel_w_ff);
               rsp_in.dropped         = drop;
            end
            OpComplete: begin
               if (wid_ok_ff) begin
                  if ((pend == 8'd0) || (len_ff == 8'd0)) begin
                     rsp_in.underflow   = 1'b1;
                     rsp_in.worker_load = len_ff;
                  end else begin
                     tbl_wr_en = 1'b1;
                     load_we   = 1'b1;
                     load_in   = len_dec;
                     rsp_in.worker_load = len_dec;
                     // last pending request unbinds the client
                     if (pend_dec == 8'd0) begin
                        tbl_wr_data = {entry_ff[EntryWidth-1 -: 6], 1'b0,
                                       {WorkerBits{1'b0}}, pend_dec};
                     end else begin
                        tbl_wr_data = {entry_ff[EntryWidth-1:8], pend_dec};
                     end
                  end
               end
            end
            default: begin
               tbl_wr_en = 1'b0;
            end
         endcase
      end
   end

   // written bits, worker loads, turn pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
         turn_ff    <= '0;
         for (int i = 0; i < WORKERS; i++) begin
            load_ff[i] <= 8'd0;
         end
      end else begin
         if (tbl_wr_en) begin
            written_ff[addr_ff] <= 1'b1;
         end
         if (load_we) begin
            load_ff[sel_w_ff] <= load_in;
         end
         turn_ff <= turn_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= (state_ff == StCommit);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == StCommit) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule
`default_nettype wire
